[rtl/core/jrsa_pkg.sv]
package jrsa_pkg;

	// Fraction bits of the Q-format fields
	localparam int FRAC_BITS = 12;

	// One result bit per stage in every root and quotient unit
	localparam int STEPS = 32;

	// Request to result strobe, in clock edges
	localparam int PIPE_LAT = 4 * STEPS + 11;

	localparam logic signed [24:0] ONE_Q = 25'sd1 <<< FRAC_BITS;
	localparam logic [31:0] ONE_U = 32'd1 << FRAC_BITS;

	localparam logic signed [23:0] OUT_MAX = 24'sh7fffff;
	localparam logic signed [23:0] OUT_MIN = 24'sh800000;

	// Running state of a digit-by-digit square root
	typedef struct packed {
		logic [63:0] rem;
		logic [31:0] root;
	} sqrt_t;

	// Running state of a restoring division; low holds numerator bits still to shift in
	typedef struct packed {
		logic [32:0] rem;
		logic [31:0] quot;
		logic [31:0] low;
	} div_t;

	// Decide root bit k: keep it if the remainder covers (2*root + 2^k) * 2^k
	function automatic sqrt_t sqrt_step(input sqrt_t x, input int k);
		sqrt_t r;
		logic [63:0] trial;
		trial = (64'(x.root) << (k + 1)) | (64'd1 << (2 * k));
		r = x;
		if (x.rem >= trial) begin
			r.rem = x.rem - trial;
			r.root = x.root | (32'd1 << k);
		end
		return r;
	endfunction

	// Shift in the next numerator bit and decide one quotient bit
	function automatic div_t div_step(input div_t x, input logic [31:0] den);
		div_t r;
		logic [32:0] trial;
		trial = {x.rem[31:0], x.low[31]};
		r.low = {x.low[30:0], 1'b0};
		r.rem = trial;
		r.quot = {x.quot[30:0], 1'b0};
		if (trial >= {1'b0, den}) begin
			r.rem = trial - {1'b0, den};
			r.quot = {x.quot[30:0], 1'b1};
		end
		return r;
	endfunction

endpackage

[rtl/core/jacobian_rotation_scale_average_core.sv]
// Channel   Handshake            Payload
// request   start, busy          disp_x, disp_y, dx_of_disp_x, dx_of_disp_y,
//                                dy_of_disp_x, dy_of_disp_y
// result    done (one cycle)     jac_xx, jac_yx, jac_xy, jac_yy, anchor_weight, degenerate
//
// A request is taken on every edge with start high; busy stays low.
// Each result follows its request through the pipeline, one result per cycle.
// The pipeline holds four 32-stage units (two roots, two dividers), one bit per stage.
// arst_n clears the valid bits only; requests in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module jacobian_rotation_scale_average_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [23:0] disp_x,
	input  logic signed [23:0] disp_y,
	input  logic signed [23:0] dx_of_disp_x,
	input  logic signed [23:0] dx_of_disp_y,
	input  logic signed [23:0] dy_of_disp_x,
	input  logic signed [23:0] dy_of_disp_y,
	output logic               done,
	output logic signed [23:0] jac_xx,
	output logic signed [23:0] jac_yx,
	output logic signed [23:0] jac_xy,
	output logic signed [23:0] jac_yy,
	output logic [12:0]        anchor_weight,
	output logic               degenerate
);

	logic               accept;
	logic signed [24:0] a_e;
	logic signed [24:0] b_e;
	logic signed [24:0] c_e;
	logic signed [24:0] d_e;
	logic signed [24:0] x_p0, x_q0, x_p1, x_q1;
	logic signed [24:0] y_p0, y_q0, y_p1, y_q1;
	logic               deg_x;
	logic               deg_y;

	// Never hold off a request
	assign busy = 1'b0;
	assign accept = start && !busy;

	// Build both candidate vectors of each column
	always_comb begin
		a_e = {dx_of_disp_x[23], dx_of_disp_x};
		b_e = {dx_of_disp_y[23], dx_of_disp_y};
		c_e = {dy_of_disp_x[23], dy_of_disp_x};
		d_e = {dy_of_disp_y[23], dy_of_disp_y};
		x_p0 = jrsa_pkg::ONE_Q - a_e;
		x_q0 = -b_e;
		x_p1 = jrsa_pkg::ONE_Q + a_e;
		x_q1 = b_e;
		y_p0 = -c_e;
		y_q0 = jrsa_pkg::ONE_Q - d_e;
		y_p1 = c_e;
		y_q1 = jrsa_pkg::ONE_Q + d_e;
	end

	// First column also carries the weight
	jrsa_col u_col_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.p0        (x_p0),
		.q0        (x_q0),
		.p1        (x_p1),
		.q1        (x_q1),
		.wx        (disp_x),
		.wy        (disp_y),
		.out_valid (done),
		.ox        (jac_xx),
		.oy        (jac_yx),
		.deg       (deg_x),
		.weight    (anchor_weight)
	);

	jrsa_col u_col_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.p0        (y_p0),
		.q0        (y_q0),
		.p1        (y_p1),
		.q1        (y_q1),
		.wx        ('0),
		.wy        ('0),
		.out_valid (),
		.ox        (jac_xy),
		.oy        (jac_yy),
		.deg       (deg_y),
		.weight    ()
	);

	assign degenerate = deg_x || deg_y;

endmodule

[rtl/core/jrsa_col.sv]
module jrsa_col (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [24:0] p0,
	input  logic signed [24:0] q0,
	input  logic signed [24:0] p1,
	input  logic signed [24:0] q1,
	input  logic signed [23:0] wx,
	input  logic signed [23:0] wy,
	output logic               out_valid,
	output logic signed [23:0] ox,
	output logic signed [23:0] oy,
	output logic               deg,
	output logic [12:0]        weight
);

	localparam int WS_W = jrsa_pkg::FRAC_BITS + 13;
	localparam logic [WS_W-1:0] HALF = WS_W'(1) << (jrsa_pkg::FRAC_BITS - 1);

	typedef struct packed {
		logic [3:0][23:0] mag;
		logic [3:0]       neg;
		logic             deg;
	} sba_t;

	typedef struct packed {
		logic [1:0][31:0] len;
		logic [3:0]       neg;
		logic             deg;
		logic [12:0]      w;
	} sbb_t;

	typedef struct packed {
		logic [1:0][31:0] len;
		logic [1:0]       neg;
		logic             deg;
		logic [12:0]      w;
	} sbc_t;

	typedef struct packed {
		logic [1:0][31:0] mmag;
		logic [1:0]       neg;
		logic             deg;
		logic [12:0]      w;
	} sbd_t;

	typedef struct packed {
		logic [31:0] lm;
		logic [31:0] sc;
		logic [1:0]  neg;
		logic        deg;
		logic [12:0] w;
	} sbe_t;

	function automatic logic [23:0] mag25(input logic signed [24:0] v);
		logic signed [24:0] n;
		n = -v;
		return v[24] ? n[23:0] : v[23:0];
	endfunction

	function automatic logic signed [33:0] apply_sign(input logic [31:0] q, input logic neg);
		logic signed [33:0] s;
		s = $signed({2'b00, q});
		return neg ? -s : s;
	endfunction

	function automatic logic [31:0] mag34(input logic signed [33:0] v);
		logic signed [33:0] n;
		n = -v;
		return v[33] ? n[31:0] : v[31:0];
	endfunction

	// Round half away from zero at bit 37, then clamp to the output range
	function automatic logic signed [23:0] round_sat(input logic [63:0] prod, input logic neg);
		logic [63:0] r;
		logic [63:0] n;
		r = (prod + (64'd1 << 36)) >> 37;
		n = -r;
		if (!neg) begin
			return (r > 64'(jrsa_pkg::OUT_MAX)) ? jrsa_pkg::OUT_MAX : r[23:0];
		end
		return (r > 64'd8388608) ? jrsa_pkg::OUT_MIN : n[23:0];
	endfunction

	// Stage 1: magnitudes and signs
	logic             v_s1;
	logic [5:0][23:0] mag_s1;
	logic [3:0]       neg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1[0] <= mag25(p0);
		mag_s1[1] <= mag25(q0);
		mag_s1[2] <= mag25(p1);
		mag_s1[3] <= mag25(q1);
		mag_s1[4] <= mag25({wx[23], wx});
		mag_s1[5] <= mag25({wy[23], wy});
		neg_s1 <= {q1[24], p1[24], q0[24], p0[24]};
	end

	// Stage 2: squares
	logic             v_s2;
	logic [5:0][47:0] prod_s2;
	logic [3:0][23:0] mag_s2;
	logic [3:0]       neg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 6; j++) begin
			prod_s2[j] <= 48'(mag_s1[j]) * 48'(mag_s1[j]);
		end
		for (int j = 0; j < 4; j++) begin
			mag_s2[j] <= mag_s1[j];
		end
		neg_s2 <= neg_s1;
	end

	// Stage 3: squared lengths enter the first root unit
	logic [48:0] s0_sum;
	logic [48:0] s1_sum;
	logic [48:0] w_sum;

	always_comb begin
		s0_sum = 49'(prod_s2[0]) + 49'(prod_s2[1]);
		s1_sum = 49'(prod_s2[2]) + 49'(prod_s2[3]);
		w_sum = 49'(prod_s2[4]) + 49'(prod_s2[5]);
	end

	logic              a_vld_s [jrsa_pkg::STEPS+1];
	jrsa_pkg::sqrt_t   a_st_s  [jrsa_pkg::STEPS+1][3];
	sba_t              a_sb_s  [jrsa_pkg::STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_vld_s[0] <= 1'b0;
		end else begin
			a_vld_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		a_st_s[0][0] <= '{rem: {1'b0, s0_sum, 14'b0}, root: '0};
		a_st_s[0][1] <= '{rem: {1'b0, s1_sum, 14'b0}, root: '0};
		a_st_s[0][2] <= '{rem: {15'b0, w_sum}, root: '0};
		a_sb_s[0] <= '{mag: mag_s2, neg: neg_s2, deg: (s0_sum == '0) || (s1_sum == '0)};
	end

	// Column lengths and displacement length, one root bit per stage
	for (genvar i = 0; i < jrsa_pkg::STEPS; i++) begin : g_sqa
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				a_vld_s[i+1] <= 1'b0;
			end else begin
				a_vld_s[i+1] <= a_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			for (int j = 0; j < 3; j++) begin
				a_st_s[i+1][j] <= jrsa_pkg::sqrt_step(a_st_s[i][j], jrsa_pkg::STEPS - 1 - i);
			end
			a_sb_s[i+1] <= a_sb_s[i];
		end
	end

	// Weight from the displacement length
	logic [31:0]                 disp_len;
	logic [31:0]                 wdiff;
	logic [jrsa_pkg::FRAC_BITS:0] wf;
	logic [WS_W-1:0]             wsum;
	logic [WS_W-1:0]             wshift;

	always_comb begin
		disp_len = a_st_s[jrsa_pkg::STEPS][2].root;
		wdiff = jrsa_pkg::ONE_U - disp_len;
		wf = (disp_len < jrsa_pkg::ONE_U) ? wdiff[jrsa_pkg::FRAC_BITS:0] : '0;
		wsum = {wf, 12'b0} + HALF;
		wshift = wsum >> jrsa_pkg::FRAC_BITS;
	end

	// Unit vectors: each component times 2^37 over its length
	logic            b_vld_s [jrsa_pkg::STEPS+1];
	jrsa_pkg::div_t  b_st_s  [jrsa_pkg::STEPS+1][4];
	sbb_t            b_sb_s  [jrsa_pkg::STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_vld_s[0] <= 1'b0;
		end else begin
			b_vld_s[0] <= a_vld_s[jrsa_pkg::STEPS];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 4; j++) begin
			b_st_s[0][j] <= '{rem: {4'b0, a_sb_s[jrsa_pkg::STEPS].mag[j], 5'b0},
				quot: '0, low: '0};
		end
		b_sb_s[0].len[0] <= a_st_s[jrsa_pkg::STEPS][0].root;
		b_sb_s[0].len[1] <= a_st_s[jrsa_pkg::STEPS][1].root;
		b_sb_s[0].neg <= a_sb_s[jrsa_pkg::STEPS].neg;
		b_sb_s[0].deg <= a_sb_s[jrsa_pkg::STEPS].deg;
		b_sb_s[0].w <= wshift[12:0];
	end

	for (genvar i = 0; i < jrsa_pkg::STEPS; i++) begin : g_divb
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				b_vld_s[i+1] <= 1'b0;
			end else begin
				b_vld_s[i+1] <= b_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			for (int j = 0; j < 4; j++) begin
				b_st_s[i+1][j] <= jrsa_pkg::div_step(b_st_s[i][j], b_sb_s[i].len[j/2]);
			end
			b_sb_s[i+1] <= b_sb_s[i];
		end
	end

	// Sum of the two unit vectors
	logic              v_c1;
	logic signed [33:0] mx_c1;
	logic signed [33:0] my_c1;
	sbc_t              sb_c1;
	sbb_t              b_end;

	assign b_end = b_sb_s[jrsa_pkg::STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c1 <= 1'b0;
		end else begin
			v_c1 <= b_vld_s[jrsa_pkg::STEPS];
		end
	end

	always_ff @(posedge clk) begin
		mx_c1 <= apply_sign(b_st_s[jrsa_pkg::STEPS][0].quot, b_end.neg[0])
			+ apply_sign(b_st_s[jrsa_pkg::STEPS][2].quot, b_end.neg[2]);
		my_c1 <= apply_sign(b_st_s[jrsa_pkg::STEPS][1].quot, b_end.neg[1])
			+ apply_sign(b_st_s[jrsa_pkg::STEPS][3].quot, b_end.neg[3]);
		sb_c1 <= '{len: b_end.len, neg: '0, deg: b_end.deg, w: b_end.w};
	end

	// Magnitudes of the sum
	logic             v_c2;
	logic [1:0][31:0] mmag_c2;
	sbc_t             sb_c2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c2 <= 1'b0;
		end else begin
			v_c2 <= v_c1;
		end
	end

	always_ff @(posedge clk) begin
		mmag_c2[0] <= mag34(mx_c1);
		mmag_c2[1] <= mag34(my_c1);
		sb_c2 <= '{len: sb_c1.len, neg: {my_c1[33], mx_c1[33]}, deg: sb_c1.deg, w: sb_c1.w};
	end

	// Squares of the sum and product of the lengths
	logic             v_c3;
	logic [1:0][63:0] sq_c3;
	logic [63:0]      lp_c3;
	logic [1:0][31:0] mmag_c3;
	sbc_t             sb_c3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c3 <= 1'b0;
		end else begin
			v_c3 <= v_c2;
		end
	end

	always_ff @(posedge clk) begin
		sq_c3[0] <= 64'(mmag_c2[0]) * 64'(mmag_c2[0]);
		sq_c3[1] <= 64'(mmag_c2[1]) * 64'(mmag_c2[1]);
		lp_c3 <= 64'(sb_c2.len[0]) * 64'(sb_c2.len[1]);
		mmag_c3 <= mmag_c2;
		sb_c3 <= sb_c2;
	end

	// Bisector length and scale, one root bit per stage
	logic             d_vld_s [jrsa_pkg::STEPS+1];
	jrsa_pkg::sqrt_t  d_st_s  [jrsa_pkg::STEPS+1][2];
	sbd_t             d_sb_s  [jrsa_pkg::STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_vld_s[0] <= 1'b0;
		end else begin
			d_vld_s[0] <= v_c3;
		end
	end

	always_ff @(posedge clk) begin
		d_st_s[0][0] <= '{rem: sq_c3[0] + sq_c3[1], root: '0};
		d_st_s[0][1] <= '{rem: lp_c3, root: '0};
		d_sb_s[0] <= '{mmag: mmag_c3, neg: sb_c3.neg, deg: sb_c3.deg, w: sb_c3.w};
	end

	for (genvar i = 0; i < jrsa_pkg::STEPS; i++) begin : g_sqd
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d_vld_s[i+1] <= 1'b0;
			end else begin
				d_vld_s[i+1] <= d_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			for (int j = 0; j < 2; j++) begin
				d_st_s[i+1][j] <= jrsa_pkg::sqrt_step(d_st_s[i][j], jrsa_pkg::STEPS - 1 - i);
			end
			d_sb_s[i+1] <= d_sb_s[i];
		end
	end

	// Bisector unit vector: sum times 2^30 over its length
	logic            e_vld_s [jrsa_pkg::STEPS+1];
	jrsa_pkg::div_t  e_st_s  [jrsa_pkg::STEPS+1][2];
	sbe_t            e_sb_s  [jrsa_pkg::STEPS+1];
	sbd_t            d_end;
	logic [31:0]     lm_end;

	assign d_end = d_sb_s[jrsa_pkg::STEPS];
	assign lm_end = d_st_s[jrsa_pkg::STEPS][0].root;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_vld_s[0] <= 1'b0;
		end else begin
			e_vld_s[0] <= d_vld_s[jrsa_pkg::STEPS];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 2; j++) begin
			e_st_s[0][j] <= '{rem: {3'b0, d_end.mmag[j][31:2]}, quot: '0,
				low: {d_end.mmag[j][1:0], 30'b0}};
		end
		e_sb_s[0] <= '{lm: lm_end, sc: d_st_s[jrsa_pkg::STEPS][1].root, neg: d_end.neg,
			deg: d_end.deg || (lm_end == '0), w: d_end.w};
	end

	for (genvar i = 0; i < jrsa_pkg::STEPS; i++) begin : g_dive
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				e_vld_s[i+1] <= 1'b0;
			end else begin
				e_vld_s[i+1] <= e_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			for (int j = 0; j < 2; j++) begin
				e_st_s[i+1][j] <= jrsa_pkg::div_step(e_st_s[i][j], e_sb_s[i].lm);
			end
			e_sb_s[i+1] <= e_sb_s[i];
		end
	end

	// Scale the bisector
	logic             v_f1;
	logic [1:0][63:0] prod_f1;
	logic [1:0]       neg_f1;
	logic             deg_f1;
	logic [12:0]      w_f1;
	sbe_t             e_end;

	assign e_end = e_sb_s[jrsa_pkg::STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1 <= 1'b0;
		end else begin
			v_f1 <= e_vld_s[jrsa_pkg::STEPS];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 2; j++) begin
			prod_f1[j] <= 64'(e_st_s[jrsa_pkg::STEPS][j].quot) * 64'(e_end.sc);
		end
		neg_f1 <= e_end.neg;
		deg_f1 <= e_end.deg;
		w_f1 <= e_end.w;
	end

	// Round, clamp, drop a degenerate column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_f1;
		end
	end

	always_ff @(posedge clk) begin
		ox <= deg_f1 ? '0 : round_sat(prod_f1[0], neg_f1[0]);
		oy <= deg_f1 ? '0 : round_sat(prod_f1[1], neg_f1[1]);
		deg <= deg_f1;
		weight <= w_f1;
	end

endmodule

[rtl/core/jrsa_chk.sv]
module jrsa_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [23:0] jac_xx,
	input logic [23:0] jac_yx,
	input logic [23:0] jac_xy,
	input logic [23:0] jac_yy,
	input logic [12:0] anchor_weight,
	input logic        degenerate
);

	// Every request yields a result after the fixed latency
	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(jrsa_pkg::PIPE_LAT) done)
		else $error("request without result");

	// No result without a matching request
	a_done_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, jrsa_pkg::PIPE_LAT))
		else $error("result without request");

	// A degenerate result has at least one zeroed column
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> (jac_xx == '0 && jac_yx == '0) || (jac_xy == '0 && jac_yy == '0))
		else $error("degenerate result without zero column");

	// Weight never exceeds one
	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> anchor_weight <= 13'd4096)
		else $error("weight above one");

endmodule

bind jacobian_rotation_scale_average_core jrsa_chk u_jrsa_chk (.*);

[sim/tb_jacobian_rotation_scale_average_core.sv]
`timescale 1ns / 1ps

module tb_jacobian_rotation_scale_average_core;

	localparam int WATCH_LIMIT = 20 * jrsa_pkg::PIPE_LAT + 2000;
	localparam longint ONE = 64'sd1 << jrsa_pkg::FRAC_BITS;

	typedef logic [63:0] u64_t;

	typedef struct {
		logic signed [23:0] vx, vy, a, b, c, d;
		bit drain;
	} pixel_t;

	typedef struct {
		logic signed [23:0] xx, yx, xy, yy;
		logic [12:0] weight;
		logic deg;
	} jac_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [23:0] disp_x = '0, disp_y = '0;
	logic signed [23:0] dx_of_disp_x = '0, dx_of_disp_y = '0;
	logic signed [23:0] dy_of_disp_x = '0, dy_of_disp_y = '0;
	logic done;
	logic signed [23:0] jac_xx, jac_yx, jac_xy, jac_yy;
	logic [12:0] anchor_weight;
	logic degenerate;

	pixel_t pixel_q[$];
	jac_t jac_q[$];
	pixel_t cur_pixel;
	int sent_cnt = 0;
	int err_cnt = 0;
	int quiet_cycles = 0;

	jacobian_rotation_scale_average_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.disp_x(disp_x), .disp_y(disp_y),
		.dx_of_disp_x(dx_of_disp_x), .dx_of_disp_y(dx_of_disp_y),
		.dy_of_disp_x(dy_of_disp_x), .dy_of_disp_y(dy_of_disp_y),
		.done(done), .jac_xx(jac_xx), .jac_yx(jac_yx), .jac_xy(jac_xy),
		.jac_yy(jac_yy), .anchor_weight(anchor_weight), .degenerate(degenerate)
	);

	always #10 clk = ~clk;

	// Floor square root, one bit pair at a time
	function automatic u64_t root64(input u64_t x);
		u64_t res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic u64_t abs64(input longint v);
		return v < 0 ? u64_t'(-v) : u64_t'(v);
	endfunction

	function automatic longint div_trunc(input longint num, input u64_t den);
		u64_t q;
		q = abs64(num) / den;
		return num < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [23:0] round_clip(input longint v);
		u64_t r;
		longint s;
		r = (abs64(v) + (64'd1 << 36)) >> 37;
		s = longint'(r);
		if (v < 0) s = -s;
		if (s > 64'sd8388607) s = 64'sd8388607;
		if (s < -64'sd8388608) s = -64'sd8388608;
		return s[23:0];
	endfunction

	// Bisect the two unit directions of one column and scale by the mean length
	function automatic bit bisect_column(input longint p0, q0, p1, q1,
			output logic signed [23:0] ox, oy);
		u64_t s0, s1, l0, l1, lm;
		longint mx, my, ex, ey, sc;
		ox = '0;
		oy = '0;
		s0 = abs64(p0) * abs64(p0) + abs64(q0) * abs64(q0);
		s1 = abs64(p1) * abs64(p1) + abs64(q1) * abs64(q1);
		if (s0 == 0 || s1 == 0) return 1'b1;
		l0 = root64(s0 << 14);
		l1 = root64(s1 << 14);
		mx = div_trunc(p0 <<< 37, l0) + div_trunc(p1 <<< 37, l1);
		my = div_trunc(q0 <<< 37, l0) + div_trunc(q1 <<< 37, l1);
		lm = root64(abs64(mx) * abs64(mx) + abs64(my) * abs64(my));
		if (lm == 0) return 1'b1;
		ex = div_trunc(mx <<< 30, lm);
		ey = div_trunc(my <<< 30, lm);
		sc = longint'(root64(l0 * l1));
		ox = round_clip(ex * sc);
		oy = round_clip(ey * sc);
		return 1'b0;
	endfunction

	function automatic jac_t average_jacobian(input pixel_t p);
		jac_t r;
		longint vx, vy, a, b, c, d;
		u64_t disp_len, wf;
		bit dg0, dg1;
		vx = p.vx; vy = p.vy; a = p.a; b = p.b; c = p.c; d = p.d;
		dg0 = bisect_column(ONE - a, -b, ONE + a, b, r.xx, r.yx);
		dg1 = bisect_column(-c, ONE - d, c, ONE + d, r.xy, r.yy);
		r.deg = dg0 | dg1;
		disp_len = root64(abs64(vx) * abs64(vx) + abs64(vy) * abs64(vy));
		wf = disp_len < u64_t'(ONE) ? u64_t'(ONE) - disp_len : 0;
		r.weight = 13'((wf * 4096 + (64'd1 << (jrsa_pkg::FRAC_BITS - 1)))
			>> jrsa_pkg::FRAC_BITS);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		err_cnt++;
	endtask

	function automatic pixel_t make_pixel(input longint vx, vy, a, b, c, d);
		pixel_t p;
		p.vx = vx[23:0]; p.vy = vy[23:0]; p.a = a[23:0];
		p.b = b[23:0]; p.c = c[23:0]; p.d = d[23:0];
		p.drain = 1'b0;
		return p;
	endfunction

	function automatic logic signed [23:0] rand_field(input int mode);
		int sel;
		sel = $urandom_range(99);
		if (mode == 0 || sel < 15) return 24'($urandom);
		if (sel < 25) return sel[0] ? jrsa_pkg::OUT_MAX : jrsa_pkg::OUT_MIN;
		if (sel < 35) return 24'($urandom_range(8)) - 24'sd4;
		if (sel < 45) return sel[1] ? 24'(ONE) : -24'(ONE);
		return 24'($urandom_range(4 * 4096)) - 24'sd8192;
	endfunction

	// Fill the request queue: directed corners first, then random pixels
	initial begin
		pixel_t p;
		int n;
		pixel_q.push_back(make_pixel(0, 0, 0, 0, 0, 0));
		pixel_q.push_back(make_pixel(ONE, 0, ONE, 0, 0, 0));
		pixel_q.push_back(make_pixel(0, ONE - 1, -ONE, 0, 0, ONE));
		pixel_q.push_back(make_pixel(100, -200, 0, 0, 0, -ONE));
		pixel_q.push_back(make_pixel(-2000, 2000, 2 * ONE, 0, 0, 2 * ONE));
		pixel_q.push_back(make_pixel(1, 1, -2 * ONE, 0, 0, -2 * ONE));
		pixel_q.push_back(make_pixel(8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
		pixel_q.push_back(make_pixel(-8388608, -8388608, -8388608, -8388608,
			-8388608, -8388608));
		pixel_q.push_back(make_pixel(8388607, -8388608, -8388608, 8388607,
			8388607, -8388608));
		pixel_q.push_back(make_pixel(-1, -1, -1, -1, -1, -1));
		pixel_q.push_back(make_pixel(2896, 2896, 300, -500, 700, 200));
		pixel_q.push_back(make_pixel(4095, 0, 0, 8388607, -8388608, 0));
		pixel_q.push_back(make_pixel(-4096, 0, 8388607, 0, 0, -8388608));
		pixel_q.push_back(make_pixel(0, -4095, -100, 4000, -3000, 50));
		for (int i = 0; i < 900; i++) begin
			n = $urandom_range(3);
			p.vx = rand_field(n); p.vy = rand_field(n);
			p.a = rand_field(n); p.b = rand_field(n);
			p.c = rand_field(n); p.d = rand_field(n);
			p.drain = (i == 450 || i == 700);
			pixel_q.push_back(p);
		end
	end

	// Drive requests; predict each one as it is accepted
	always @(posedge clk or negedge arst_n) begin
		bit idle;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				jac_q.push_back(average_jacobian(cur_pixel));
				sent_cnt++;
			end
			if (start && busy) begin
				start <= 1'b1;
			end else begin
				idle = (sent_cnt < 300 || sent_cnt >= 500) && $urandom_range(99) < 21;
				if (pixel_q.size() != 0 && !idle &&
						!(pixel_q[0].drain && jac_q.size() != 0)) begin
					cur_pixel = pixel_q.pop_front();
					start <= 1'b1;
					disp_x <= cur_pixel.vx;
					disp_y <= cur_pixel.vy;
					dx_of_disp_x <= cur_pixel.a;
					dx_of_disp_y <= cur_pixel.b;
					dy_of_disp_x <= cur_pixel.c;
					dy_of_disp_y <= cur_pixel.d;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Check each result against the oldest prediction
	always @(posedge clk) begin
		jac_t w;
		if (arst_n && done) begin
			if (jac_q.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				w = jac_q.pop_front();
				if (jac_xx !== w.xx) report_mismatch("jac_xx", jac_xx, w.xx);
				if (jac_yx !== w.yx) report_mismatch("jac_yx", jac_yx, w.yx);
				if (jac_xy !== w.xy) report_mismatch("jac_xy", jac_xy, w.xy);
				if (jac_yy !== w.yy) report_mismatch("jac_yy", jac_yy, w.yy);
				if (anchor_weight !== w.weight)
					report_mismatch("anchor_weight", anchor_weight, w.weight);
				if (degenerate !== w.deg) report_mismatch("degenerate", degenerate, w.deg);
			end
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("[jacobian_rotation_scale_average_core] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pixel_q.size() != 0 || start || jac_q.size() != 0) @(posedge clk);
		repeat (jrsa_pkg::PIPE_LAT + 20) @(posedge clk);
		if (err_cnt == 0 && jac_q.size() == 0) begin
			$display("[jacobian_rotation_scale_average_core] OK");
		end else begin
			if (jac_q.size() != 0) report_mismatch("results missing", 0, jac_q.size());
			$display("[jacobian_rotation_scale_average_core] ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/core/jrsa_pkg.sv
rtl/core/jrsa_col.sv
rtl/core/jacobian_rotation_scale_average_core.sv
rtl/core/jrsa_chk.sv
sim/tb_jacobian_rotation_scale_average_core.sv
